// ----- rtl/fwseq_pkg.sv -----
// shared types and constants of the flush window sequencer
`timescale 1ns / 1ps

package fwseq_pkg;

  // field widths of the request and the command
  localparam int unsigned COORD_W = 9;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned OFF_W   = 18;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned REM_W   = 19;  // pixels of one window, up to 512 x 512
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned IDX_W   = 2;

  // command cap per request
  localparam int unsigned MAX_RESULTS = 43;
  localparam int unsigned EMIT_W      = 6;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CENTER_OUT = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_HEIGHT = 2'd2;

  // reset values of the thresholds
  localparam logic [DIM_W-1:0] MIN_WIDTH_RST  = 10'd300;
  localparam logic [DIM_W-1:0] MIN_HEIGHT_RST = 10'd180;

  // controller to datapath
  typedef struct packed {
    logic load;  // latch a request
    logic plan;  // pick the next window
    logic mul;   // form window base offset and pixel total
    logic emit;  // load one command into the output register
  } fwseq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a command
    logic win_done;  // current chunk closes its window
    logic last_cmd;  // current chunk is the final command
  } fwseq_sts_t;

endpackage

// ----- rtl/fwseq_ctrl.sv -----
// controller state machine of the flush window sequencer
`timescale 1ns / 1ps

module fwseq_ctrl
  import fwseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fwseq_sts_t sts,
  output fwseq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PLAN = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          priority if (sts.last_cmd) begin
            state_nxt = S_IDLE;
          end else if (sts.win_done) begin
            state_nxt = S_PLAN;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("command emitted into a full output register");

  a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_cmd) |=> (state_r == S_IDLE))
    else $error("request not closed after its last command");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_PLAN))
    else $error("request load did not start planning");
`endif

endmodule

// ----- rtl/fwseq_dp.sv -----
// datapath of the flush window sequencer: configuration, band planning, chunking, output register
`timescale 1ns / 1ps

module fwseq_dp
  import fwseq_pkg::*;
#(
  parameter int unsigned BAND_ROWS    = 12,
  parameter int unsigned CHUNK_PIXELS = 8192
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic [COORD_W-1:0]  x_start,
  input  logic [COORD_W-1:0]  y_start,
  input  logic [COORD_W-1:0]  x_end,
  input  logic [COORD_W-1:0]  y_end,
  input  fwseq_cmd_t          cmd,
  output fwseq_sts_t          sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_new_window,
  output logic [COORD_W-1:0]  out_window_x,
  output logic [COORD_W-1:0]  out_window_y,
  output logic [DIM_W-1:0]    out_window_w,
  output logic [DIM_W-1:0]    out_window_h,
  output logic [OFF_W-1:0]    out_pixel_offset,
  output logic [CNT_W-1:0]    out_pixel_count,
  output logic                out_last
);

  localparam logic [DIM_W-1:0] BAND      = DIM_W'(BAND_ROWS);
  localparam logic [DIM_W-1:0] BAND_HALF = DIM_W'(BAND_ROWS / 2);
  localparam logic [REM_W-1:0] CHUNK     = REM_W'(CHUNK_PIXELS);

  // configuration
  logic             center_en_r;
  logic [DIM_W-1:0] min_w_r;
  logic [DIM_W-1:0] min_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_en_r <= 1'b0;
      min_w_r     <= MIN_WIDTH_RST;
      min_h_r     <= MIN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_OUT: center_en_r <= cfg_wdata[0];
        REG_MIN_WIDTH:  min_w_r     <= cfg_wdata;
        REG_MIN_HEIGHT: min_h_r     <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // request and band state
  logic [COORD_W-1:0] xs_r, ys_r;
  logic [DIM_W-1:0]   w_r, h_r;
  logic [DIM_W-1:0]   up_r, down_r, row_r, rows_r;
  logic               phase_up_r, first_r, more_r;
  logic [OFF_W-1:0]   off_r;
  logic [REM_W-1:0]   rem_r;
  logic               new_win_r;
  logic [EMIT_W-1:0]  emit_cnt_r;

  // request dimensions, end below start counts as one
  logic [DIM_W-1:0] w_in, h_in;
  assign w_in = (x_end < x_start) ? DIM_W'(1)
              : DIM_W'({1'b0, x_end} - {1'b0, x_start} + DIM_W'(1));
  assign h_in = (y_end < y_start) ? DIM_W'(1)
              : DIM_W'({1'b0, y_end} - {1'b0, y_start} + DIM_W'(1));

  // next window choice
  logic             center_mode;
  logic [DIM_W-1:0] center, fy, fh_raw, bh_raw;
  logic [DIM_W-1:0] row_nxt, rows_nxt, up_nxt, down_nxt;
  logic             phase_nxt, take_up;

  assign center_mode = center_en_r && (w_r >= min_w_r) && (h_r >= min_h_r);
  assign center      = h_r >> 1;
  assign fy          = (center > BAND_HALF) ? (center - BAND_HALF) : '0;
  assign fh_raw      = h_r - fy;
  assign bh_raw      = h_r - down_r;
  assign take_up     = (phase_up_r && (up_r != '0)) || (down_r >= h_r);

  always_comb begin
    row_nxt   = '0;
    rows_nxt  = h_r;
    up_nxt    = '0;
    down_nxt  = h_r;
    phase_nxt = 1'b1;
    if (first_r) begin
      if (center_mode) begin
        // first band around the middle row
        row_nxt  = fy;
        rows_nxt = (fh_raw > BAND) ? BAND : fh_raw;
        up_nxt   = fy;
        down_nxt = fy + rows_nxt;
      end
    end else if (take_up) begin
      row_nxt   = (up_r > BAND) ? (up_r - BAND) : '0;
      rows_nxt  = up_r - row_nxt;
      up_nxt    = row_nxt;
      down_nxt  = down_r;
      phase_nxt = 1'b0;
    end else begin
      row_nxt   = down_r;
      rows_nxt  = (bh_raw > BAND) ? BAND : bh_raw;
      up_nxt    = up_r;
      down_nxt  = down_r + rows_nxt;
      phase_nxt = 1'b1;
    end
  end

  // chunking of the current window
  logic [REM_W-1:0] chunk;
  assign chunk        = (rem_r > CHUNK) ? CHUNK : rem_r;
  assign sts.win_done = (rem_r <= CHUNK);
  assign sts.last_cmd = (sts.win_done && !more_r)
                      || (emit_cnt_r == EMIT_W'(MAX_RESULTS - 1));
  assign sts.out_free = !out_valid || out_ready;

  logic [2*DIM_W-1:0] base_prod, total_prod;
  assign base_prod  = row_r * w_r;
  assign total_prod = rows_r * w_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r       <= x_start;
      ys_r       <= y_start;
      w_r        <= w_in;
      h_r        <= h_in;
      first_r    <= 1'b1;
      emit_cnt_r <= '0;
    end
    if (cmd.plan) begin
      first_r    <= 1'b0;
      row_r      <= row_nxt;
      rows_r     <= rows_nxt;
      up_r       <= up_nxt;
      down_r     <= down_nxt;
      phase_up_r <= phase_nxt;
      more_r     <= (first_r && !center_mode) ? 1'b0
                  : ((up_nxt != '0) || (down_nxt < h_r));
    end
    if (cmd.mul) begin
      off_r     <= base_prod[OFF_W-1:0];
      rem_r     <= total_prod[REM_W-1:0];
      new_win_r <= 1'b1;
    end
    if (cmd.emit) begin
      off_r      <= off_r + chunk[OFF_W-1:0];
      rem_r      <= rem_r - chunk;
      new_win_r  <= 1'b0;
      emit_cnt_r <= emit_cnt_r + EMIT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_new_window   <= new_win_r;
      out_window_x     <= xs_r;
      out_window_y     <= ys_r + row_r[COORD_W-1:0];
      out_window_w     <= w_r;
      out_window_h     <= rows_r;
      out_pixel_offset <= off_r;
      out_pixel_count  <= chunk[CNT_W-1:0];
      out_last         <= sts.last_cmd;
    end
  end

`ifndef SYNTHESIS
  a_cap_forces_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (emit_cnt_r == EMIT_W'(MAX_RESULTS - 1))) |=> out_last)
    else $error("command at the cap not flagged last");

  a_window_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> (rem_r != '0))
    else $error("window planned with no pixels");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted command not presented");
`endif

endmodule

// ----- rtl/display_flush_window_sequencer.sv -----
// top level of the flush window sequencer
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata: x_start, y_start, x_end, y_end
//  out_    | out | out_tvalid/tready  | out_tdata: window command, out_tlast: last
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// a request is taken in one transfer, then per window one plan step, one multiply
// step and one emit step per chunk; defaults: 32 chunks for a full single window,
// up to 43 center-out bands
// the next request is taken as soon as the last command sits in the output register
// rst_n is synchronous; it clears the controller, the output valid and the
// configuration (center-out off, thresholds 300 and 180)
// a stalled output holds the command and the controller waits in its emit state
`timescale 1ns / 1ps

module display_flush_window_sequencer
  import fwseq_pkg::*;
#(
  parameter int unsigned BAND_ROWS    = 12,
  parameter int unsigned CHUNK_PIXELS = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration writes
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // flush requests
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,   // x_start, y_start, x_end, y_end, zero pad
  // write commands
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,  // new_window, window_x, window_y, window_w,
                                       // window_h, pixel_offset, pixel_count, zero pad
  output logic             out_tlast
);

  fwseq_cmd_t cmd;
  fwseq_sts_t sts;

  logic               new_window;
  logic [COORD_W-1:0] window_x, window_y;
  logic [DIM_W-1:0]   window_w, window_h;
  logic [OFF_W-1:0]   pixel_offset;
  logic [CNT_W-1:0]   pixel_count;

  // sequencing of load, planning, multiply and emit
  fwseq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // band arithmetic, chunk split, config registers and output register
  fwseq_dp #(
    .BAND_ROWS    (BAND_ROWS),
    .CHUNK_PIXELS (CHUNK_PIXELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .x_start          (in_tdata[8:0]),
    .y_start          (in_tdata[17:9]),
    .x_end            (in_tdata[26:18]),
    .y_end            (in_tdata[35:27]),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_new_window   (new_window),
    .out_window_x     (window_x),
    .out_window_y     (window_y),
    .out_window_w     (window_w),
    .out_window_h     (window_h),
    .out_pixel_offset (pixel_offset),
    .out_pixel_count  (pixel_count),
    .out_last         (out_tlast)
  );

  // pack the command, first field in the lowest bit
  assign out_tdata = {1'b0, pixel_count, pixel_offset, window_h, window_w,
                      window_y, window_x, new_window};

endmodule

// ----- tb/tb_display_flush_window_sequencer.sv -----
// testbench of the flush window sequencer: directed table and random requests checked by a predictor
`timescale 1ns / 1ps

module tb_display_flush_window_sequencer;
  import fwseq_pkg::*;

  // block parameters, kept at their defaults
  localparam int BAND_ROWS    = 12;
  localparam int CHUNK_PIXELS = 8192;

  // index with no register behind it, writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  // random part: three idling phases, new register setting every CFG_EVERY requests
  localparam int RAND_PER_PHASE = 160;
  localparam int CFG_EVERY      = 40;
  // receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES    = 300;
  // wait after the last command, longer than the longest request
  localparam int TAIL_CYCLES    = 150;
  // longest quiet stretch of a correct run is the hold-off plus one full request
  // behind a stalling receiver
  localparam int QUIET_LIMIT    = 3000;

  // one flush request, members high to low so the vector matches in_tdata
  typedef struct packed {
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xs;
  } flush_req_t;

  // one write command as the block should send it
  typedef struct packed {
    logic               new_window;
    logic [COORD_W-1:0] win_x;
    logic [COORD_W-1:0] win_y;
    logic [DIM_W-1:0]   win_w;
    logic [DIM_W-1:0]   win_h;
    logic [OFF_W-1:0]   pix_off;
    logic [CNT_W-1:0]   pix_cnt;
    logic               last;
  } write_cmd_t;

  // directed row: register setting, rectangle, and for single-command cases the
  // command typed in (new window, offset 0, last set)
  typedef struct packed {
    logic [CFG_W-1:0]   co;
    logic [CFG_W-1:0]   mw;
    logic [CFG_W-1:0]   mh;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic               typed;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [DIM_W-1:0]   ew;
    logic [DIM_W-1:0]   eh;
    logic [CNT_W-1:0]   ecnt;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // reset setting, single window order
    '{0, 300, 180,   0,   0,   0,   0, 1,   0,   0,   1,  1,    1},  // one pixel at origin
    '{0, 300, 180, 511, 511, 511, 511, 1, 511, 511,   1,  1,    1},  // one pixel at far corner
    '{0, 300, 180,   0,   0, 511, 511, 0,   0,   0,   0,  0,    0},  // full panel, 32 chunks
    '{0, 300, 180, 300,   7,  20,   3, 1, 300,   7,   1,  1,    1},  // both ends before start
    '{0, 300, 180,  10,  20,   5, 100, 1,  10,  20,   1, 81,   81},  // x end before start
    '{0, 300, 180,   0,   0, 511,   0, 1,   0,   0, 512,  1,  512},  // one full row
    '{0, 300, 180,   0,   0, 511,  15, 1,   0,   0, 512, 16, 8192},  // exactly one chunk
    '{0, 300, 180,   0,   0, 511,  16, 0,   0,   0,   0,  0,    0},  // one chunk plus a row
    // center-out at reset thresholds
    '{1, 300, 180,   0,   0, 511, 511, 0,   0,   0,   0,  0,    0},  // full panel, 43 bands
    '{1, 300, 180, 100,  50, 399, 229, 0,   0,   0,   0,  0,    0},  // both at threshold
    '{1, 300, 180, 100,  50, 398, 229, 0,   0,   0,   0,  0,    0},  // one column short
    '{1, 300, 180, 100,  50, 399, 228, 0,   0,   0,   0,  0,    0},  // one row short
    // zero thresholds always pass
    '{1,   0,   0,   5,   5,   5,   5, 1,   5,   5,   1,  1,    1},  // single pixel band
    '{1,   0,   0,   0,   0,   0,  12, 0,   0,   0,   0,  0,    0},  // first band clamped to top
    '{1,   0,   0,   3,   4,  40,  27, 0,   0,   0,   0,  0,    0},  // three bands
    // largest and out-of-range thresholds
    '{1, 512, 512,   0,   0, 511, 511, 0,   0,   0,   0,  0,    0},
    '{1, 1023, 1023, 0,   0, 511, 511, 0,   0,   0,   0,  0,    0},  // never passes
    '{1, 513,   1,   0,   0, 511, 100, 0,   0,   0,   0,  0,    0},
    // enable written with upper bits set and bit 0 clear
    '{10'h3FE, 1, 1, 0,   0, 511, 511, 0,   0,   0,   0,  0,    0},
    '{1,   1,   1, 200, 300, 100, 200, 0,   0,   0,   0,  0,    0}   // center-out, ends swapped
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [39:0]      in_tdata = '0;   // x_start, y_start, x_end, y_end, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [71:0]      out_tdata;       // new_window, window_x, window_y, window_w,
                                     // window_h, pixel_offset, pixel_count, zero pad
  logic             out_tlast;

  // predictor's copy of the registers
  logic co_en = 1'b0;
  int   min_w = 300;
  int   min_h = 180;

  write_cmd_t expected_cmds[$];  // commands still owed by the block, oldest first
  int         cmds_this_req;     // commands predicted for the request at hand
  int         fail_cnt = 0;
  int         quiet_cycles = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  logic       hold_req = 1'b0;

  display_flush_window_sequencer #(
    .BAND_ROWS   (BAND_ROWS),
    .CHUNK_PIXELS(CHUNK_PIXELS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one address window cut into chunks, never past the command cap
  function automatic void add_window(int x, int y, int w, int h, int base);
    int left;
    int off;
    int c;
    write_cmd_t cmd;
    left = w * h;
    off  = 0;
    cmd.new_window = 1'b1;
    while (left > 0 && cmds_this_req < MAX_RESULTS) begin
      c = (left > CHUNK_PIXELS) ? CHUNK_PIXELS : left;
      cmd.win_x   = COORD_W'(x);
      cmd.win_y   = COORD_W'(y);
      cmd.win_w   = DIM_W'(w);
      cmd.win_h   = DIM_W'(h);
      cmd.pix_off = OFF_W'(base + off);
      cmd.pix_cnt = CNT_W'(c);
      cmd.last    = 1'b0;
      expected_cmds.push_back(cmd);
      cmds_this_req++;
      cmd.new_window = 1'b0;
      off  += c;
      left -= c;
    end
  endfunction

  // commands of one flush request under the current register setting
  function automatic void predict_flush(flush_req_t r);
    int xs, ys, xe, ye, w, h;
    int top, first_h, up, down, y0, bh;
    write_cmd_t tail;
    xs = r.xs;
    ys = r.ys;
    xe = (r.xe < r.xs) ? r.xs : r.xe;  // end before start collapses to one pixel
    ye = (r.ye < r.ys) ? r.ys : r.ye;
    w  = xe - xs + 1;
    h  = ye - ys + 1;
    cmds_this_req = 0;
    if (co_en && w >= min_w && h >= min_h) begin
      // band around the middle row, clamped at the top edge
      top = h / 2 - BAND_ROWS / 2;
      if (top < 0) top = 0;
      first_h = (h - top > BAND_ROWS) ? BAND_ROWS : h - top;
      add_window(xs, ys + top, w, first_h, top * w);
      up   = top;
      down = top + first_h;
      // then alternate one band above, one band below
      while ((up > 0 || down < h) && cmds_this_req < MAX_RESULTS) begin
        if (up > 0) begin
          y0 = (up > BAND_ROWS) ? up - BAND_ROWS : 0;
          add_window(xs, ys + y0, w, up - y0, y0 * w);
          up = y0;
        end
        if (down < h) begin
          bh = (h - down > BAND_ROWS) ? BAND_ROWS : h - down;
          add_window(xs, ys + down, w, bh, down * w);
          down += bh;
        end
      end
    end else begin
      add_window(xs, ys, w, h, 0);
    end
    if (cmds_this_req > 0) begin
      tail = expected_cmds.pop_back();
      tail.last = 1'b1;
      expected_cmds.push_back(tail);
    end
  endfunction

  function automatic string cmd_str(write_cmd_t c);
    return $sformatf("nw=%0d x=%0d y=%0d w=%0d h=%0d off=%0d cnt=%0d last=%0d",
                     c.new_window, c.win_x, c.win_y, c.win_w, c.win_h,
                     c.pix_off, c.pix_cnt, c.last);
  endfunction

  task automatic log_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // start and inclusive end of one side of a random rectangle, end in the upper half
  function automatic logic [17:0] make_span(int kind, int thr);
    int a, b, len;
    case (kind)
      0: begin  // small
        a = $urandom_range(511);
        len = $urandom_range(31);
        b = (a + len > 511) ? 511 : a + len;
      end
      1: begin  // anywhere, ends swapped half the time
        a = $urandom_range(511);
        b = $urandom_range(511);
      end
      2: begin  // close to the full panel
        a = $urandom_range(15);
        b = $urandom_range(511, 448);
      end
      3: begin  // around the center-out threshold
        len = thr + $urandom_range(2) - 1;
        if (len < 1) len = 1;
        if (len > 512) len = 512;
        a = $urandom_range(512 - len);
        b = a + len - 1;
      end
      default: begin  // end strictly before start
        a = $urandom_range(511, 1);
        b = $urandom_range(a - 1);
      end
    endcase
    return {COORD_W'(b), COORD_W'(a)};
  endfunction

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return $urandom_range(1) ? CFG_W'(512) : CFG_W'(1023);
      2:       return CFG_W'($urandom_range(64, 1));
      3:       return CFG_W'($urandom_range(1023));
      4:       return CFG_W'($urandom_range(512, 1));
      default: return $urandom_range(1) ? MIN_WIDTH_RST : MIN_HEIGHT_RST;
    endcase
  endfunction

  // all registers in consecutive cycles plus a write to the spare index
  task automatic write_config(logic [CFG_W-1:0] co, logic [CFG_W-1:0] mw,
                              logic [CFG_W-1:0] mh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CENTER_OUT;
    cfg_wdata <= co;
    @(negedge clk);
    cfg_index <= REG_MIN_WIDTH;
    cfg_wdata <= mw;
    @(negedge clk);
    cfg_index <= REG_MIN_HEIGHT;
    cfg_wdata <= mh;
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    co_en = co[0];
    min_w = mw;
    min_h = mh;
  endtask

  // stop offering and let every owed command drain out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // offer one request after a random gap; expectations are queued at the transfer
  task automatic send_req(flush_req_t r, logic typed, write_cmd_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, r};
    do @(posedge clk); while (!in_tready);
    if (typed) expected_cmds.push_back(want);
    else predict_flush(r);
    @(negedge clk);
  endtask

  // receiver: random stalls, or one long hold-off once it is asked for
  initial begin
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // check every command transfer against the oldest expectation
  always @(posedge clk) begin
    write_cmd_t got;
    write_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.new_window = out_tdata[0];
      got.win_x      = out_tdata[9:1];
      got.win_y      = out_tdata[18:10];
      got.win_w      = out_tdata[28:19];
      got.win_h      = out_tdata[38:29];
      got.pix_off    = out_tdata[56:39];
      got.pix_cnt    = out_tdata[70:57];
      got.last       = out_tlast;
      if (expected_cmds.size() == 0) begin
        log_fail({"command with none owed: ", cmd_str(got)});
      end else begin
        want = expected_cmds.pop_front();
        if (got.new_window !== want.new_window || got.win_x !== want.win_x ||
            got.win_y !== want.win_y || got.win_w !== want.win_w ||
            got.win_h !== want.win_h || got.pix_off !== want.pix_off ||
            got.pix_cnt !== want.pix_cnt || got.last !== want.last) begin
          log_fail({"expected ", cmd_str(want), " got ", cmd_str(got)});
        end
      end
    end
  end

  // watchdog on stretches with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t            row;
    flush_req_t          r;
    write_cmd_t          want;
    logic [3*CFG_W-1:0]  cfg_raw;
    logic [CFG_W-1:0]    co;
    logic [17:0]         xspan;
    logic [17:0]         yspan;
    int                  k;
    int                  kind;

    cfg_raw = '1;  // no table row carries this, so the first row writes
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the first idling mix
    snd_idle_pct = 24;
    rcv_idle_pct = 64;
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TAB[i];
      if ({row.co, row.mw, row.mh} != cfg_raw) begin
        wait_idle();
        write_config(row.co, row.mw, row.mh);
        cfg_raw = {row.co, row.mw, row.mh};
      end
      r = {row.ye, row.xe, row.ys, row.xs};
      want = '{new_window: 1'b1, win_x: row.ex, win_y: row.ey, win_w: row.ew,
               win_h: row.eh, pix_off: '0, pix_cnt: row.ecnt, last: 1'b1};
      send_req(r, row.typed, want);
    end

    // random part: sender light and receiver heavy, then swapped, then no idling
    want = '0;
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 64 : 0;
      rcv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 24 : 0;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % CFG_EVERY == 0) begin
          wait_idle();
          co = CFG_W'($urandom);
          co[0] = ($urandom_range(3) != 0);  // center-out on most of the time
          write_config(co, pick_threshold(), pick_threshold());
        end
        // back the block up while requests keep coming
        if (ph == 0 && i == 20) hold_req = 1'b1;
        k = $urandom_range(9);
        kind = (k < 4) ? 0 : (k < 6) ? 1 : (k < 8) ? 2 : (k == 8) ? 3 : 4;
        xspan = make_span(kind, min_w);
        yspan = make_span(kind, min_h);
        r = {yspan[17:9], xspan[17:9], yspan[8:0], xspan[8:0]};
        send_req(r, 1'b0, want);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && expected_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
